// ===== hdl/fltw_pkg.sv =====
// shared types and constants for the four level page table walker
`timescale 1ns / 1ps
package fltw_pkg;
  localparam int TABLES_DEF = 16;
  localparam int ENTRIES = 512;
  localparam int HUGE_FLAG_BIT_DEF = 9;
  localparam logic [1:0] ACT_MAP = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_CONFLICT = 2'd3;
  localparam logic [0:0] CFG_ROOT = 1'b0;
  localparam logic [0:0] CFG_BASE = 1'b1;
  typedef struct packed {
    logic [1:0] action;
    logic [47:0] virt;
    logic [63:0] phys;
    logic [63:0] flags;
    logic [5:0] order;
  } req_t;
  typedef struct packed {
    logic [1:0] status;
    logic [63:0] phys_out;
    logic [63:0] entry_out;
  } rsp_t;
endpackage

// ===== hdl/fltw_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module fltw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/four_level_page_table_walker_unit.sv =====
// top level: page table walker sequencer around the table store
// latency: each level read passes S_RD, S_WAIT and S_EVAL; a leaf write adds S_LEAF before S_OUT
// each newly allocated table is cleared by 512 writes in S_ZERO, then linked by the link write in S_LINK
// throughput: one request at a time; the next is taken in the cycle after the result beat
// reset: a clearing pass in S_CLR writes all TABLES*512 entries before the first request is taken
// after reset root_table and table_base_page are 0 and the allocator is at table 1
`timescale 1ns / 1ps
module four_level_page_table_walker_unit
  import fltw_pkg::*;
#(
  parameter int TABLES = TABLES_DEF,
  parameter int HUGE_FLAG_BIT = HUGE_FLAG_BIT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [39:0] cfg_data
);
  localparam int TW = $clog2(TABLES);
  localparam int AW = TW + 9;
  localparam int CW = $clog2(TABLES + 1);

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD = 4'd2;
  localparam logic [3:0] S_WAIT = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_ZERO = 4'd5;
  localparam logic [3:0] S_LINK = 4'd6;
  localparam logic [3:0] S_LEAF = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state;
  logic [3:0] root_table;
  logic [39:0] table_base_page;
  logic [CW-1:0] next_free;
  logic [AW-1:0] clr_addr;
  req_t req;
  logic [1:0] level;
  logic [TW-1:0] cur;
  logic [TW-1:0] newt;
  logic [8:0] zidx;
  logic [63:0] wr_val;
  rsp_t rsp;

  logic we;
  logic [AW-1:0] addr;
  logic [63:0] wdata;
  logic [63:0] rdata;

  fltw_ram #(.WIDTH(64), .DEPTH(TABLES * ENTRIES)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [8:0] idx;
  always_comb begin
    case (level)
      2'd0: idx = req.virt[47:39];
      2'd1: idx = req.virt[38:30];
      2'd2: idx = req.virt[29:21];
      default: idx = req.virt[20:12];
    endcase
  end

  logic [39:0] dframe;
  logic fol_ok;
  logic [TW-1:0] fol_t;
  always_comb begin
    dframe = rdata[51:12] - table_base_page;
    fol_ok = dframe < 40'(TABLES);
    fol_t = dframe[TW-1:0];
  end

  logic huge_map;
  assign huge_map = (req.order >= 6'd9) || req.flags[HUGE_FLAG_BIT];
  logic [63:0] huge_mask;
  assign huge_mask = ~(64'd1 << HUGE_FLAG_BIT);
  logic full;
  assign full = next_free >= CW'(TABLES);
  logic [39:0] new_frame;
  assign new_frame = table_base_page + 40'(next_free);
  logic root_bad;
  assign root_bad = 32'(root_table) >= TABLES;

  always_comb begin
    we = 1'b0;
    addr = {cur, idx};
    wdata = wr_val;
    case (state)
      S_CLR: begin
        we = 1'b1; addr = clr_addr; wdata = '0;
      end
      S_ZERO: begin
        we = 1'b1; addr = {newt, zidx}; wdata = '0;
      end
      S_LINK, S_LEAF: we = 1'b1;
      default: ;
    endcase
  end

  assign in_stall = state != S_IDLE;
  assign cfg_ready = state == S_IDLE || state == S_CLR;
  assign out_valid = state == S_OUT;
  assign out_data = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      next_free <= CW'(1);
      root_table <= '0;
      table_base_page <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROOT) root_table <= cfg_data[3:0];
        else table_base_page <= cfg_data;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLES * ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            level <= 2'd0;
            cur <= TW'(root_table);
            rsp <= '{status: (in_data.action != ACT_NOP && root_bad) ? ST_MISS : ST_OK,
                     phys_out: 64'd0, entry_out: 64'd0};
            if (in_data.action == ACT_NOP || root_bad) state <= S_OUT;
            else state <= S_RD;
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= S_EVAL;
        S_EVAL: begin
          if (req.action == ACT_MAP) begin
            if (level == 2'd2 && huge_map) begin
              wr_val <= ({req.phys[63:21], 21'd0}) | (req.flags & huge_mask) | 64'h83;
              state <= S_LEAF;
            end else if (level == 2'd3) begin
              wr_val <= {req.phys[63:12], 12'd0} | req.flags | 64'h1;
              state <= S_LEAF;
            end else if (level == 2'd2 && rdata[0] && rdata[7]) begin
              rsp.status <= ST_CONFLICT;
              state <= S_OUT;
            end else if (!rdata[0]) begin
              if (full) begin
                rsp.status <= ST_FULL;
                state <= S_OUT;
              end else begin
                newt <= next_free[TW-1:0];
                next_free <= next_free + 1'b1;
                wr_val <= {12'd0, new_frame, 12'h007};
                zidx <= '0;
                state <= S_ZERO;
              end
            end else if (fol_ok) begin
              cur <= fol_t; level <= level + 1'b1; state <= S_RD;
            end else begin
              rsp.status <= ST_MISS;
              state <= S_OUT;
            end
          end else if (level == 2'd3) begin
            if (rdata[0] && req.action == ACT_LOOKUP)
              rsp <= '{status: ST_OK, phys_out: {rdata[63:12], req.virt[11:0]},
                       entry_out: rdata};
            else rsp.status <= rdata[0] ? ST_OK : ST_MISS;
            if (req.action == ACT_UNMAP) begin
              wr_val <= '0; state <= S_LEAF;
            end else state <= S_OUT;
          end else if (level == 2'd2 && rdata[0] && rdata[7]) begin
            if (req.action == ACT_LOOKUP) begin
              rsp <= '{status: ST_OK, phys_out: {rdata[63:21], req.virt[20:0]},
                       entry_out: rdata};
              state <= S_OUT;
            end else begin
              rsp.status <= ST_OK;
              wr_val <= '0; state <= S_LEAF;
            end
          end else if (rdata[0] && fol_ok) begin
            cur <= fol_t; level <= level + 1'b1; state <= S_RD;
          end else begin
            rsp.status <= ST_MISS;
            state <= S_OUT;
          end
        end
        S_ZERO: begin
          zidx <= zidx + 1'b1;
          if (zidx == 9'h1ff) state <= S_LINK;
        end
        S_LINK: begin
          cur <= newt; level <= level + 1'b1; state <= S_RD;
        end
        S_LEAF: state <= S_OUT;
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
